[rtl/dvc_pkg.sv]
// dvc_pkg: request, status and event codes of the dispense volume controller.
// No dependencies; imported by dvc_req_if and every module.
`timescale 1ns / 1ps

package dvc_pkg;

    // request kinds
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_PULSE = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ACTIVE     = 2'd1;
    localparam logic [1:0] ST_PRESS_LOST = 2'd2;
    localparam logic [1:0] ST_SAMPLE_ERR = 2'd3;

    // result events
    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_STOPPED    = 2'd1;
    localparam logic [1:0] EV_PRESS_LOST = 2'd2;

    // configuration register indexes
    localparam logic CFG_VALVE_THR   = 1'b0;
    localparam logic CFG_LOST_CUTOFF = 1'b1;

    localparam int unsigned PRESS_W      = 12;
    localparam int unsigned VALVE_MARGIN = 30;

endpackage

[rtl/dvc_if.sv]
// dvc_req_if / dvc_rsp_if: valid-ready channels for request and result words.
// Depends on dvc_pkg.
`timescale 1ns / 1ps

interface dvc_req_if
    import dvc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [2:0]         size_code;
    logic [6:0]         deciliters;
    logic [PRESS_W-1:0] pressure_sample;
    logic               sample_ok;

    modport source (output valid, req_type, size_code, deciliters, pressure_sample,
                    sample_ok, input ready);
    modport sink   (input valid, req_type, size_code, deciliters, pressure_sample,
                    sample_ok, output ready);
endinterface

interface dvc_rsp_if #(
    parameter int unsigned COUNT_WIDTH = 13
) ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [1:0]             event_code;
    logic                   pump_drive;
    logic                   valve_drive;
    logic                   run_active;
    logic [COUNT_WIDTH-1:0] pulses_counted;

    modport source (output valid, status, event_code, pump_drive, valve_drive, run_active,
                    pulses_counted, input ready);
    modport sink   (input valid, status, event_code, pump_drive, valve_drive, run_active,
                    pulses_counted, output ready);
endinterface

[rtl/dvc_target.sv]
// dvc_target: target pulse count of a run from the size code or deciliters.
// Combinational; depends on dvc_pkg.
`timescale 1ns / 1ps

module dvc_target
    import dvc_pkg::*;
#(
    parameter int unsigned PULSES_PER_DECILITER = 42,
    parameter int unsigned COUNT_WIDTH          = 13
) (
    input  logic [2:0]             i_size_code,
    input  logic [6:0]             i_deciliters,
    output logic [COUNT_WIDTH-1:0] o_target,
    output logic                   o_open_ended
);

    localparam logic [2:0] SIZE_OPEN = 3'd0;
    localparam logic [2:0] SIZE_Q250 = 3'd1;
    localparam logic [2:0] SIZE_Q330 = 3'd2;
    localparam logic [2:0] SIZE_Q500 = 3'd3;
    localparam logic [2:0] SIZE_Q750 = 3'd4;
    localparam logic [2:0] SIZE_L1   = 3'd5;

    localparam longint unsigned CMAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam longint unsigned STEP = PULSES_PER_DECILITER + 7;

    localparam int unsigned STEP_W = $clog2(PULSES_PER_DECILITER + 8);
    localparam int unsigned PROD_W = 7 + STEP_W;
    localparam int unsigned WW     = ((PROD_W > COUNT_WIDTH) ? PROD_W : COUNT_WIDTH) + 1;

    // Q(d) = d*(P+7) - 7 for d >= 1, saturated to the count range
    function automatic logic [COUNT_WIDTH-1:0] preset(input longint unsigned d,
                                                      input longint unsigned extra);
        longint unsigned v;
        begin
            v = d * STEP - 64'd7 + extra;
            preset = (v > CMAX) ? COUNT_WIDTH'(CMAX) : COUNT_WIDTH'(v);
        end
    endfunction

    localparam logic [COUNT_WIDTH-1:0] T_Q250 = preset(2, PULSES_PER_DECILITER / 2);
    localparam logic [COUNT_WIDTH-1:0] T_Q330 = preset(3, PULSES_PER_DECILITER / 3);
    localparam logic [COUNT_WIDTH-1:0] T_Q500 = preset(5, 0);
    localparam logic [COUNT_WIDTH-1:0] T_Q750 = preset(7, PULSES_PER_DECILITER / 2);
    localparam logic [COUNT_WIDTH-1:0] T_L1   = preset(10, 0);

    localparam logic [STEP_W-1:0] STEP_V  = STEP_W'(STEP);
    localparam logic [WW-1:0]     CMAX_W  = WW'(CMAX);
    localparam logic [WW-1:0]     SEVEN_W = WW'(7);

    logic [PROD_W-1:0] prod;
    logic [WW-1:0]     prod_w;
    logic [WW-1:0]     q_dl;
    logic [COUNT_WIDTH-1:0] t_dl;

    assign prod   = PROD_W'(i_deciliters) * PROD_W'(STEP_V);
    assign prod_w = WW'(prod);
    // zero deciliters clamps to a zero target
    assign q_dl   = (prod_w >= SEVEN_W) ? (prod_w - SEVEN_W) : '0;
    assign t_dl   = (q_dl > CMAX_W) ? COUNT_WIDTH'(CMAX) : q_dl[COUNT_WIDTH-1:0];

    always_comb begin
        o_open_ended = 1'b0;
        unique case (i_size_code)
            SIZE_OPEN: begin
                o_open_ended = 1'b1;
                o_target     = '0;
            end
            SIZE_Q250: o_target = T_Q250;
            SIZE_Q330: o_target = T_Q330;
            SIZE_Q500: o_target = T_Q500;
            SIZE_Q750: o_target = T_Q750;
            SIZE_L1:   o_target = T_L1;
            default:   o_target = t_dl;   // deciliter code and the unused code
        endcase
    end

endmodule

[rtl/dvc_core.sv]
// dvc_core: run state (active, pump, valve, counts) and its per-word update.
// Depends on dvc_pkg; target comes from dvc_target.
`timescale 1ns / 1ps

module dvc_core
    import dvc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [1:0]             i_req_type,
    input  logic [PRESS_W-1:0]     i_pressure_sample,
    input  logic                   i_sample_ok,
    input  logic [COUNT_WIDTH-1:0] i_target,
    input  logic                   i_open_ended,
    input  logic [PRESS_W-1:0]     i_valve_thr,
    input  logic [PRESS_W-1:0]     i_lost_cutoff,
    output logic [1:0]             o_status,
    output logic [1:0]             o_event_code,
    output logic                   o_pump,
    output logic                   o_valve,
    output logic                   o_active,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic                   r_active, n_active;
    logic                   r_pump, n_pump;
    logic                   r_valve, n_valve;
    logic                   r_open, n_open;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_target, n_target;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [PRESS_W:0]       open_level;

    assign count_inc  = (r_count != '1) ? r_count + 1'b1 : r_count;
    assign open_level = {1'b0, i_valve_thr} + (PRESS_W + 1)'(VALVE_MARGIN);

    always_comb begin
        n_active     = r_active;
        n_pump       = r_pump;
        n_valve      = r_valve;
        n_open       = r_open;
        n_count      = r_count;
        n_target     = r_target;
        o_status     = ST_OK;
        o_event_code = EV_NONE;
        unique case (i_req_type)
            REQ_START: begin
                if (r_active) begin
                    o_status = ST_ACTIVE;
                end else begin
                    n_active = 1'b1;
                    n_pump   = 1'b1;
                    n_count  = '0;
                    n_open   = i_open_ended;
                    n_target = i_target;
                end
            end
            REQ_STOP: begin
                n_active     = 1'b0;
                n_pump       = 1'b0;
                n_valve      = 1'b0;
                o_event_code = EV_STOPPED;
            end
            REQ_PULSE: begin
                if (r_active) begin
                    n_count = count_inc;
                    if (!r_open && count_inc >= r_target) begin
                        n_active     = 1'b0;
                        n_pump       = 1'b0;
                        n_valve      = 1'b0;
                        o_event_code = EV_STOPPED;
                    end
                end
            end
            REQ_TICK: begin
                if (r_active) begin
                    if (!i_sample_ok) begin
                        o_status = ST_SAMPLE_ERR;
                    end else if ({1'b0, i_pressure_sample} > open_level) begin
                        n_valve = 1'b1;
                    end else if (r_valve && i_pressure_sample < i_lost_cutoff) begin
                        n_active     = 1'b0;
                        n_pump       = 1'b0;
                        n_valve      = 1'b0;
                        o_status     = ST_PRESS_LOST;
                        o_event_code = EV_PRESS_LOST;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pump   <= 1'b0;
            r_valve  <= 1'b0;
            r_open   <= 1'b0;
            r_count  <= '0;
            r_target <= '0;
        end else if (i_fire) begin
            r_active <= n_active;
            r_pump   <= n_pump;
            r_valve  <= n_valve;
            r_open   <= n_open;
            r_count  <= n_count;
            r_target <= n_target;
        end
    end

    assign o_pump   = n_pump;
    assign o_valve  = n_valve;
    assign o_active = n_active;
    assign o_count  = n_count;

endmodule

[rtl/dispense_volume_controller.sv]
// dispense_volume_controller: top level, request and result registers, config registers.
// Depends on dvc_pkg, dvc_if, dvc_target, dvc_core.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+--------------------------------------------------
//  i_req    | in  | valid / ready   | req_type, size_code, deciliters, pressure, ok
//  o_rsp    | out | valid / ready   | status, event_code, pump, valve, active, pulses
//  i_cfg_*  | in  | write enable    | idx 0 valve threshold, idx 1 pressure cutoff
//
// One word per cycle sustained while o_rsp.ready stays high; an accepted word loads the
// request register and then, once the result register can advance, the result register,
// which raises o_rsp.valid. The state update sits between the two registers.
// Reset (synchronous, active low) clears run state, config registers and valid flags.
// A stalled result holds the result register; the request register still takes one
// more word, after which i_req.ready follows o_rsp.ready.
`timescale 1ns / 1ps

module dispense_volume_controller
    import dvc_pkg::*;
#(
    parameter int unsigned PULSES_PER_DECILITER = 42,
    parameter int unsigned COUNT_WIDTH          = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [PRESS_W-1:0] i_cfg_data,
    dvc_req_if.sink            i_req,
    dvc_rsp_if.source          o_rsp
);

    logic [PRESS_W-1:0] r_valve_thr;
    logic [PRESS_W-1:0] r_lost_cutoff;

    logic               r_in_valid;
    logic [1:0]         r_req_type;
    logic [2:0]         r_size_code;
    logic [6:0]         r_deciliters;
    logic [PRESS_W-1:0] r_pressure;
    logic               r_sample_ok;

    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic [1:0]             r_event_code;
    logic                   r_pump;
    logic                   r_valve;
    logic                   r_active;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   advance;
    logic                   fire;
    logic                   in_ready;
    logic [COUNT_WIDTH-1:0] target;
    logic                   open_ended;
    logic [1:0]             n_status;
    logic [1:0]             n_event_code;
    logic                   n_pump;
    logic                   n_valve;
    logic                   n_active;
    logic [COUNT_WIDTH-1:0] n_count;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign fire        = r_in_valid && advance;
    assign in_ready    = !r_in_valid || advance;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_thr   <= '0;
            r_lost_cutoff <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VALVE_THR:   r_valve_thr   <= i_cfg_data;
                CFG_LOST_CUTOFF: r_lost_cutoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
        if (in_ready && i_req.valid) begin
            r_req_type   <= i_req.req_type;
            r_size_code  <= i_req.size_code;
            r_deciliters <= i_req.deciliters;
            r_pressure   <= i_req.pressure_sample;
            r_sample_ok  <= i_req.sample_ok;
        end
    end

    dvc_target #(
        .PULSES_PER_DECILITER (PULSES_PER_DECILITER),
        .COUNT_WIDTH          (COUNT_WIDTH)
    ) u_target (
        .i_size_code  (r_size_code),
        .i_deciliters (r_deciliters),
        .o_target     (target),
        .o_open_ended (open_ended)
    );

    dvc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_req_type        (r_req_type),
        .i_pressure_sample (r_pressure),
        .i_sample_ok       (r_sample_ok),
        .i_target          (target),
        .i_open_ended      (open_ended),
        .i_valve_thr       (r_valve_thr),
        .i_lost_cutoff     (r_lost_cutoff),
        .o_status          (n_status),
        .o_event_code      (n_event_code),
        .o_pump            (n_pump),
        .o_valve           (n_valve),
        .o_active          (n_active),
        .o_count           (n_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (fire) begin
            r_status     <= n_status;
            r_event_code <= n_event_code;
            r_pump       <= n_pump;
            r_valve      <= n_valve;
            r_active     <= n_active;
            r_count      <= n_count;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.event_code     = r_event_code;
    assign o_rsp.pump_drive     = r_pump;
    assign o_rsp.valve_drive    = r_valve;
    assign o_rsp.run_active     = r_active;
    assign o_rsp.pulses_counted = r_count;

    // pump and valve are only driven during a run
    a_drive_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_active |-> !r_pump && !r_valve)
        else $error("pump or valve driven outside a run");

    // every stop event leaves the run inactive
    a_event_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_event_code != EV_NONE |-> !r_active)
        else $error("stop event reported with run still active");

    // a refused start only happens while a run is in progress
    a_refused_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_ACTIVE |-> r_active && r_event_code == EV_NONE)
        else $error("already-active status without an active run");

    // a result is produced exactly when the request stage advances
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed word produced no result");

endmodule
